### rtl/kne_pkg.sv
// Package with the shared types, codes and helper functions of the keypad number entry block.
package kne_pkg;

  localparam int TICKS_W  = 16;
  localparam int KEY_W    = 4;
  localparam int DIGIT_W  = 4;
  localparam int NUMBER_W = 10;

  // Operation codes of a request.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Key codes.
  localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_ZERO  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_STAR  = 4'd11;
  localparam logic [KEY_W-1:0] KEY_POUND = 4'd12;

  // Reset value of the inter-digit tick register.
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd3000;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_RECV_A     = 4'd1,
    ST_RECV_B     = 4'd2,
    ST_RECV_C     = 4'd3,
    ST_RECV_D     = 4'd4,
    ST_RECV_E     = 4'd5,
    ST_RECV_F     = 4'd6,
    ST_CANCELLING = 4'd7,
    ST_FINISHED   = 4'd8,
    ST_CANCELLED  = 4'd9,
    ST_TIMEOUT    = 4'd10
  } state_t;

  typedef enum logic [1:0] {
    DISP_KEEP  = 2'd0,
    DISP_BLANK = 2'd1,
    DISP_SHOW  = 2'd2
  } disp_t;

  typedef enum logic [1:0] {
    BEEP_NONE   = 2'd0,
    BEEP_SHORT1 = 2'd1,
    BEEP_SHORT2 = 2'd2,
    BEEP_HALF1  = 2'd3
  } beep_t;

  // Everything the machine keeps from one request to the next.
  typedef struct packed {
    state_t               state;
    logic [TICKS_W-1:0]   counter;
    logic [DIGIT_W-1:0]   first_digit;
    logic [DIGIT_W-1:0]   second_digit;
    logic [DIGIT_W-1:0]   third_digit;
    logic [NUMBER_W-1:0]  last_number;
  } ctx_t;

  // One result item.
  typedef struct packed {
    logic [3:0]           status;
    logic [NUMBER_W-1:0]  number;
    disp_t                display_action;
    logic [DIGIT_W-1:0]   display_digit;
    beep_t                beep;
  } res_t;

  function automatic logic is_digit_key(input logic [KEY_W-1:0] k);
    return (k inside {[4'd1:4'd9]}) || (k == KEY_ZERO);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [KEY_W-1:0] k);
    return (k == KEY_ZERO) ? '0 : k;
  endfunction

  // Multiply a decimal digit by ten with shifts and one add.
  function automatic logic [NUMBER_W-1:0] mul10(input logic [DIGIT_W-1:0] d);
    logic [NUMBER_W-1:0] x;
    x = {{(NUMBER_W-DIGIT_W){1'b0}}, d};
    return (x << 3) + (x << 1);
  endfunction

  // Multiply a decimal digit by one hundred (64 + 32 + 4).
  function automatic logic [NUMBER_W-1:0] mul100(input logic [DIGIT_W-1:0] d);
    logic [NUMBER_W-1:0] x;
    x = {{(NUMBER_W-DIGIT_W){1'b0}}, d};
    return (x << 6) + (x << 5) + (x << 2);
  endfunction

endpackage

### rtl/kne_step.sv
// Combinational step logic: next machine context and the result of one request.
module kne_step (
  input  kne_pkg::ctx_t                  ctx,
  input  logic                           operation,
  input  logic [kne_pkg::KEY_W-1:0]      key,
  input  logic [kne_pkg::TICKS_W-1:0]    interdigit_ticks,
  output kne_pkg::ctx_t                  ctx_next,
  output kne_pkg::res_t                  res
);

  logic                          digit;
  logic [kne_pkg::DIGIT_W-1:0]   dval;
  logic                          tmo_check;

  assign digit = kne_pkg::is_digit_key(key);
  assign dval  = kne_pkg::digit_value(key);

  // Next state and stored data.
  always_comb begin
    ctx_next  = ctx;
    tmo_check = 1'b0;
    if (operation == kne_pkg::OP_TICK) begin
      if (ctx.counter != '0) begin
        ctx_next.counter = ctx.counter - 1'b1;
      end
    end else begin
      unique case (ctx.state)
        kne_pkg::ST_IDLE: begin
          if (digit) begin
            ctx_next.first_digit  = dval;
            ctx_next.second_digit = '0;
            ctx_next.third_digit  = '0;
            ctx_next.counter      = interdigit_ticks;
            ctx_next.state        = kne_pkg::ST_RECV_A;
          end else if (key == kne_pkg::KEY_STAR) begin
            ctx_next.state = kne_pkg::ST_CANCELLING;
          end
        end
        kne_pkg::ST_RECV_A, kne_pkg::ST_RECV_C, kne_pkg::ST_RECV_E: begin
          if (key == kne_pkg::KEY_NONE) begin
            ctx_next.counter = interdigit_ticks;
            ctx_next.state   = (ctx.state == kne_pkg::ST_RECV_A) ? kne_pkg::ST_RECV_B :
                               (ctx.state == kne_pkg::ST_RECV_C) ? kne_pkg::ST_RECV_D :
                                                                   kne_pkg::ST_RECV_F;
          end
          tmo_check = 1'b1;
        end
        kne_pkg::ST_RECV_B: begin
          if (key == kne_pkg::KEY_STAR) begin
            ctx_next.state = kne_pkg::ST_CANCELLING;
          end else if (digit) begin
            ctx_next.second_digit = dval;
            ctx_next.counter      = interdigit_ticks;
            ctx_next.state        = kne_pkg::ST_RECV_C;
          end else if (key == kne_pkg::KEY_POUND) begin
            // A single digit: it is moved to the units place.
            ctx_next.third_digit = ctx.first_digit;
            ctx_next.first_digit = '0;
            ctx_next.last_number = {{(kne_pkg::NUMBER_W-kne_pkg::DIGIT_W){1'b0}},
                                    ctx.first_digit};
            ctx_next.state       = kne_pkg::ST_FINISHED;
          end
          tmo_check = 1'b1;
        end
        kne_pkg::ST_RECV_D: begin
          if (key == kne_pkg::KEY_STAR) begin
            ctx_next.state = kne_pkg::ST_CANCELLING;
          end else if (digit) begin
            ctx_next.third_digit = dval;
            ctx_next.counter     = interdigit_ticks;
            ctx_next.state       = kne_pkg::ST_RECV_E;
          end else if (key == kne_pkg::KEY_POUND) begin
            ctx_next.third_digit = ctx.first_digit;
            ctx_next.last_number = kne_pkg::mul10(ctx.first_digit)
                                 + {{(kne_pkg::NUMBER_W-kne_pkg::DIGIT_W){1'b0}},
                                    ctx.second_digit};
            ctx_next.state       = kne_pkg::ST_FINISHED;
          end
          tmo_check = 1'b1;
        end
        kne_pkg::ST_RECV_F: begin
          if (key == kne_pkg::KEY_STAR) begin
            ctx_next.state = kne_pkg::ST_CANCELLING;
          end else if (key == kne_pkg::KEY_POUND) begin
            ctx_next.last_number = kne_pkg::mul100(ctx.first_digit)
                                 + kne_pkg::mul10(ctx.second_digit)
                                 + {{(kne_pkg::NUMBER_W-kne_pkg::DIGIT_W){1'b0}},
                                    ctx.third_digit};
            ctx_next.state       = kne_pkg::ST_FINISHED;
          end
          tmo_check = 1'b1;
        end
        kne_pkg::ST_CANCELLING: begin
          ctx_next.state = kne_pkg::ST_CANCELLED;
        end
        default: begin
          ctx_next.state = kne_pkg::ST_IDLE;
        end
      endcase
      // The timeout test sees the counter after any reload in this step.
      if (tmo_check && (ctx_next.counter == '0)) begin
        ctx_next.state = kne_pkg::ST_TIMEOUT;
      end
    end
  end

  // Display and beep outputs.
  always_comb begin
    res.status         = ctx_next.state;
    res.number         = ctx_next.last_number;
    res.display_action = kne_pkg::DISP_KEEP;
    res.display_digit  = '0;
    res.beep           = kne_pkg::BEEP_NONE;
    if (operation == kne_pkg::OP_SCAN) begin
      unique case (ctx.state)
        kne_pkg::ST_IDLE: begin
          if (digit) begin
            res.display_action = kne_pkg::DISP_SHOW;
            res.display_digit  = dval;
            res.beep           = kne_pkg::BEEP_SHORT1;
          end
        end
        kne_pkg::ST_RECV_A, kne_pkg::ST_RECV_C, kne_pkg::ST_RECV_E: begin
          if (key == kne_pkg::KEY_NONE) begin
            res.display_action = kne_pkg::DISP_BLANK;
          end
        end
        kne_pkg::ST_RECV_B, kne_pkg::ST_RECV_D: begin
          if (key == kne_pkg::KEY_STAR) begin
            res.beep = kne_pkg::BEEP_NONE;
          end else if (digit) begin
            res.display_action = kne_pkg::DISP_SHOW;
            res.display_digit  = dval;
            res.beep           = kne_pkg::BEEP_SHORT1;
          end else if (key == kne_pkg::KEY_POUND) begin
            res.beep = kne_pkg::BEEP_SHORT2;
          end
        end
        kne_pkg::ST_RECV_F: begin
          if (key == kne_pkg::KEY_POUND) begin
            res.beep = kne_pkg::BEEP_SHORT2;
          end
        end
        kne_pkg::ST_CANCELLING: begin
          res.display_action = kne_pkg::DISP_BLANK;
          res.beep           = kne_pkg::BEEP_HALF1;
        end
        default: begin
          res.beep = kne_pkg::BEEP_NONE;
        end
      endcase
    end
  end

endmodule

### rtl/keypad_number_entry_fsm.sv
// Top level of the keypad number entry block: request register, state and result register.
//
// Collects a one- to three-digit decimal number from keypad scan samples and
// timer ticks. Every accepted request yields exactly one result, and results
// leave in request order. A request first lands in an input register, then
// passes through one level of step logic that updates the entry state and
// fills the result register. A new request can be accepted in every cycle
// while the result register is not stalled downstream, so the sustained rate
// is one request per cycle. The machine state is updated in the same cycle
// the result is registered, so back-to-back requests always see the state
// left by the previous one. in_stall rises only when the input register holds
// a request and the result register is full and stalled downstream. The
// inter-digit tick count is written through cfg_we/cfg_wdata and is loaded
// into the timer when a digit is accepted and when a key is released; write
// it only while the block is idle.
module keypad_number_entry_fsm (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_we,
  input  logic [kne_pkg::TICKS_W-1:0]     cfg_wdata,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [kne_pkg::KEY_W-1:0]       key,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [3:0]                      status,
  output logic [kne_pkg::NUMBER_W-1:0]    number,
  output logic [1:0]                      display_action,
  output logic [kne_pkg::DIGIT_W-1:0]     display_digit,
  output logic [1:0]                      beep
);

  // Configuration register.
  logic [kne_pkg::TICKS_W-1:0] interdigit_ticks;

  // Input register.
  logic                        req_valid;
  logic                        req_op;
  logic [kne_pkg::KEY_W-1:0]   req_key;

  // Machine context and result register.
  kne_pkg::ctx_t ctx;
  kne_pkg::ctx_t ctx_next;
  kne_pkg::res_t res_next;
  kne_pkg::res_t res;

  logic advance;

  // The held request moves on when the result register is free or being drained.
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      interdigit_ticks <= kne_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      interdigit_ticks <= cfg_wdata;
    end
  end

  // The input register reloads whenever it is not stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_op  <= operation;
      req_key <= key;
    end
  end

  kne_step u_step (
    .ctx              (ctx),
    .operation        (req_op),
    .key              (req_key),
    .interdigit_ticks (interdigit_ticks),
    .ctx_next         (ctx_next),
    .res              (res_next)
  );

  // State advances exactly when a result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state        <= kne_pkg::ST_IDLE;
      ctx.counter      <= '0;
      ctx.first_digit  <= '0;
      ctx.second_digit <= '0;
      ctx.third_digit  <= '0;
      ctx.last_number  <= '0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign status         = res.status;
  assign number         = res.number;
  assign display_action = res.display_action;
  assign display_digit  = res.display_digit;
  assign beep           = res.beep;

endmodule
